// File: hw/rtl/gmps_pkg.sv
// Package for the grid maze path search unit: shared types, codes and constants.
// Used by gmps_cfg, gmps_ctrl, gmps_dpath and grid_maze_path_search_unit.
`timescale 1ns / 1ps

package gmps_pkg;

    // Default grid capacity
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // Register port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Field widths
    localparam int DIM_W   = 7;                // num_rows / num_cols
    localparam int POS_W   = 6;                // start/end coordinates
    localparam int DIM_MAX = 127;              // largest value a DIM_W register holds
    localparam int LIMIT_W = 2 * DIM_W;        // rows * cols

    // Register reset values
    localparam logic [DIM_W-1:0] NUM_ROWS_RST = DIM_W'(64);
    localparam logic [DIM_W-1:0] NUM_COLS_RST = DIM_W'(64);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ROW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_COL   = 3'd5;

    // Neighbor order: north, east, south, west
    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_E = 2'd1,
        DIR_S = 2'd2,
        DIR_W = 2'd3
    } dir_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_START_ADDR,
        ST_START_MARK,
        ST_EXPAND,
        ST_NB_ADDR,
        ST_NB_READ,
        ST_NB_CHECK,
        ST_TOP_READ,
        ST_TOP_LOAD,
        ST_DONE
    } state_t;

    // Effective configuration
    typedef struct packed {
        logic [DIM_W-1:0] rows_eff;
        logic [DIM_W-1:0] cols_eff;
        logic [POS_W-1:0] start_row;
        logic [POS_W-1:0] start_col;
        logic [POS_W-1:0] end_row;
        logic [POS_W-1:0] end_col;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load;        // store the accepted cell
        logic init;        // seed the stack with the start cell
        logic calc_np;     // form the linear position of the candidate cell
        logic mark;        // mark the candidate cell visited
        logic expand;      // take the next direction of the top entry
        logic push;        // mark the candidate visited and push it
        logic top_load;    // refill the top entry from the stack memory
        logic clear;       // clear one store entry
        logic clear_grid;  // include the grid store in the clear
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic start_eq_goal;
        logic start_outside;
        logic in_grid;     // neighbor of the top entry lies in the grid
        logic dir_last;    // top entry is on its last direction
        logic popped;      // last expansion removed the top entry
        logic cell_free;   // candidate is open and not yet visited
        logic at_goal;     // candidate is the goal cell
        logic sp_zero;
        logic clear_last;
    } stat_t;

endpackage

// File: hw/rtl/grid_maze_path_search_unit.sv
// Top level of the grid maze path search unit: configuration registers,
// controller and datapath. Depends on gmps_pkg, gmps_cfg, gmps_ctrl, gmps_dpath.
`timescale 1ns / 1ps

// Channel   | Handshake                  | Payload
// ----------+----------------------------+-------------------------------
// cell in   | start, taken when !busy    | cell_open, last_cell
// result    | done, one-cycle strobe     | path_found
// config    | cfg_we, no wait            | cfg_index, cfg_data
//
// Cells load one per cycle while idle; the item with last_cell high starts
// the search and busy rises on the next cycle.
// The search is a depth-first walk over one grid store port: each neighbor
// probe steps through direction step, position multiply, store read and
// check; a probe outside the grid takes only the direction step, and a
// return to a lower stack entry adds a stack read and a top reload. done
// then pulses once with path_found. After reset and after every result, a
// clearing pass over min(MAX_ROWS,127) * min(MAX_COLS,127) store entries
// (4096 at the defaults) holds busy high. The result side cannot stall.
module grid_maze_path_search_unit
    import gmps_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic                  cell_open,
    input  logic                  last_cell,
    output logic                  done,
    output logic                  path_found
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    // Register file: holds grid size and end points between mazes
    gmps_cfg #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer: load, search steps, result strobe, clearing pass
    gmps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_cell  (last_cell),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done),
        .path_found (path_found)
    );

    // Stores and arithmetic of the walk
    gmps_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .cell_open (cell_open),
        .stat      (stat)
    );

endmodule

// File: hw/rtl/gmps_cfg.sv
// Configuration register file of the grid maze path search unit.
// Depends on gmps_pkg.
`timescale 1ns / 1ps

module gmps_cfg
    import gmps_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    localparam int ROW_CAP = (MAX_ROWS < DIM_MAX) ? MAX_ROWS : DIM_MAX;
    localparam int COL_CAP = (MAX_COLS < DIM_MAX) ? MAX_COLS : DIM_MAX;

    logic [DIM_W-1:0] num_rows_reg;
    logic [DIM_W-1:0] num_cols_reg;
    logic [POS_W-1:0] start_row_reg;
    logic [POS_W-1:0] start_col_reg;
    logic [POS_W-1:0] end_row_reg;
    logic [POS_W-1:0] end_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg  <= NUM_ROWS_RST;
            num_cols_reg  <= NUM_COLS_RST;
            start_row_reg <= '0;
            start_col_reg <= '0;
            end_row_reg   <= '0;
            end_col_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_ROWS:  num_rows_reg  <= cfg_data[DIM_W-1:0];
                CFG_NUM_COLS:  num_cols_reg  <= cfg_data[DIM_W-1:0];
                CFG_START_ROW: start_row_reg <= cfg_data[POS_W-1:0];
                CFG_START_COL: start_col_reg <= cfg_data[POS_W-1:0];
                CFG_END_ROW:   end_row_reg   <= cfg_data[POS_W-1:0];
                CFG_END_COL:   end_col_reg   <= cfg_data[POS_W-1:0];
                default:       ;
            endcase
        end
    end

    // Clamp the grid size to the store capacity
    always_comb
    begin
        cfg.rows_eff  = (num_rows_reg > DIM_W'(ROW_CAP)) ? DIM_W'(ROW_CAP) : num_rows_reg;
        cfg.cols_eff  = (num_cols_reg > DIM_W'(COL_CAP)) ? DIM_W'(COL_CAP) : num_cols_reg;
        cfg.start_row = start_row_reg;
        cfg.start_col = start_col_reg;
        cfg.end_row   = end_row_reg;
        cfg.end_col   = end_col_reg;
    end

endmodule

// File: hw/rtl/gmps_ctrl.sv
// Controller of the grid maze path search unit: load, search and clear sequencing.
// Depends on gmps_pkg; drives the command struct of gmps_dpath.
`timescale 1ns / 1ps

module gmps_ctrl
    import gmps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  last_cell,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy,
    output logic  done,
    output logic  path_found
);

    state_t state_reg, state_next;
    logic   found_reg, found_next;
    logic   clr_grid_reg, clr_grid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            found_reg    <= 1'b0;
            clr_grid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            found_reg    <= found_next;
            clr_grid_reg <= clr_grid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        found_next    = found_reg;
        clr_grid_next = clr_grid_reg;
        cmd           = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear      = 1'b1;
                cmd.clear_grid = clr_grid_reg;
                if (stat.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_cell)
                        state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (stat.start_eq_goal)
                begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end
                else if (stat.start_outside)
                begin
                    found_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.init   = 1'b1;
                    state_next = ST_START_ADDR;
                end
            end
            ST_START_ADDR:
            begin
                cmd.calc_np = 1'b1;
                state_next  = ST_START_MARK;
            end
            ST_START_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = ST_EXPAND;
            end
            ST_EXPAND:
            begin
                cmd.expand = 1'b1;
                if (stat.in_grid)
                    state_next = ST_NB_ADDR;
                else if (stat.dir_last)
                    state_next = ST_TOP_READ;
            end
            ST_NB_ADDR:
            begin
                cmd.calc_np = 1'b1;
                state_next  = ST_NB_READ;
            end
            ST_NB_READ:
            begin
                state_next = ST_NB_CHECK;
            end
            ST_NB_CHECK:
            begin
                if (stat.cell_free && stat.at_goal)
                begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end
                else if (stat.cell_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_EXPAND;
                end
                else if (stat.popped)
                    state_next = ST_TOP_READ;
                else
                    state_next = ST_EXPAND;
            end
            ST_TOP_READ:
            begin
                if (stat.sp_zero)
                begin
                    found_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_TOP_LOAD;
            end
            ST_TOP_LOAD:
            begin
                cmd.top_load = 1'b1;
                state_next   = ST_EXPAND;
            end
            ST_DONE:
            begin
                clr_grid_next = 1'b1;
                state_next    = ST_CLEAR;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = (state_reg == ST_DONE);
    assign path_found = found_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_last_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_cell) |=> (busy && !done))
        else $error("final cell did not start the search");

endmodule

// File: hw/rtl/gmps_dpath.sv
// Datapath of the grid maze path search unit: grid, visited and stack stores,
// top-of-stack registers, neighbor and position arithmetic. Depends on gmps_pkg.
`timescale 1ns / 1ps

module gmps_dpath
    import gmps_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  cmd_t  cmd,
    input  logic  cell_open,
    output stat_t stat
);

    localparam int ROW_CAP = (MAX_ROWS < DIM_MAX) ? MAX_ROWS : DIM_MAX;
    localparam int COL_CAP = (MAX_COLS < DIM_MAX) ? MAX_COLS : DIM_MAX;
    localparam int USED    = ROW_CAP * COL_CAP;
    localparam int R_W     = $clog2(ROW_CAP);
    localparam int C_W     = $clog2(COL_CAP);
    localparam int A_W     = $clog2(USED);
    localparam int SP_W    = $clog2(USED + 1);
    localparam int PW      = R_W + DIM_W;
    localparam int SE_W    = R_W + C_W + 2;

    // Stores
    logic            grid_mem  [USED];
    logic            visit_mem [USED];
    logic [SE_W-1:0] stack_mem [USED];

    // Control registers
    logic [SP_W-1:0] sp_reg;
    logic [SP_W-1:0] load_pos_reg;
    logic [A_W-1:0]  clr_addr_reg;

    // Payload registers
    logic [R_W-1:0]  top_r_reg;
    logic [C_W-1:0]  top_c_reg;
    dir_t            top_dir_reg;
    logic [R_W-1:0]  nb_r_reg;
    logic [C_W-1:0]  nb_c_reg;
    logic            popped_reg;
    logic [A_W-1:0]  np_reg;
    logic            grid_rd_reg;
    logic            visit_rd_reg;
    logic [SE_W-1:0] stack_rd_reg;

    logic [R_W-1:0]     nb_r;
    logic [C_W-1:0]     nb_c;
    logic               in_grid;
    logic [SP_W-1:0]    sp_m1;
    logic [LIMIT_W-1:0] limit;
    logic               load_ok;
    logic [PW-1:0]      np_sum;

    // Neighbor of the top entry in its current direction
    always_comb
    begin
        nb_r    = top_r_reg;
        nb_c    = top_c_reg;
        in_grid = 1'b0;
        case (top_dir_reg)
            DIR_N:
            begin
                in_grid = (top_r_reg != '0);
                nb_r    = top_r_reg - 1'b1;
            end
            DIR_E:
            begin
                in_grid = ((8'(top_c_reg) + 8'd1) < {1'b0, cfg.cols_eff});
                nb_c    = top_c_reg + 1'b1;
            end
            DIR_S:
            begin
                in_grid = ((8'(top_r_reg) + 8'd1) < {1'b0, cfg.rows_eff});
                nb_r    = top_r_reg + 1'b1;
            end
            DIR_W:
            begin
                in_grid = (top_c_reg != '0);
                nb_c    = top_c_reg - 1'b1;
            end
            default:
            begin
                in_grid = 1'b0;
            end
        endcase
    end

    assign sp_m1   = sp_reg - 1'b1;
    assign limit   = LIMIT_W'(cfg.rows_eff) * LIMIT_W'(cfg.cols_eff);
    assign load_ok = (LIMIT_W'(load_pos_reg) < limit);
    assign np_sum  = PW'(nb_r_reg) * PW'(cfg.cols_eff) + PW'(nb_c_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg       <= '0;
            load_pos_reg <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                sp_reg       <= '0;
                load_pos_reg <= '0;
                clr_addr_reg <= (clr_addr_reg == A_W'(USED - 1)) ? '0 : clr_addr_reg + 1'b1;
            end
            if (cmd.load && load_ok)
                load_pos_reg <= load_pos_reg + 1'b1;
            if (cmd.init)
                sp_reg <= SP_W'(1);
            if (cmd.expand && (top_dir_reg == DIR_W))
                sp_reg <= sp_m1;
            if (cmd.push)
                sp_reg <= sp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            top_r_reg   <= R_W'(cfg.start_row);
            top_c_reg   <= C_W'(cfg.start_col);
            top_dir_reg <= DIR_N;
            nb_r_reg    <= R_W'(cfg.start_row);
            nb_c_reg    <= C_W'(cfg.start_col);
        end
        if (cmd.expand)
        begin
            nb_r_reg    <= nb_r;
            nb_c_reg    <= nb_c;
            popped_reg  <= (top_dir_reg == DIR_W);
            top_dir_reg <= dir_t'(2'(top_dir_reg + 2'd1));
        end
        if (cmd.push)
        begin
            top_r_reg   <= nb_r_reg;
            top_c_reg   <= nb_c_reg;
            top_dir_reg <= DIR_N;
        end
        if (cmd.top_load)
        begin
            top_r_reg   <= stack_rd_reg[SE_W-1 -: R_W];
            top_c_reg   <= stack_rd_reg[C_W+1 -: C_W];
            top_dir_reg <= dir_t'(stack_rd_reg[1:0]);
        end
        if (cmd.calc_np)
            np_reg <= np_sum[A_W-1:0];
    end

    // Grid store: load writes, clear sweep, candidate read
    always_ff @(posedge clk)
    begin
        if (cmd.clear && cmd.clear_grid)
            grid_mem[clr_addr_reg] <= 1'b0;
        else if (cmd.load && load_ok)
            grid_mem[load_pos_reg[A_W-1:0]] <= cell_open;
        grid_rd_reg <= grid_mem[np_reg];
    end

    // Visited store
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
            visit_mem[clr_addr_reg] <= 1'b0;
        else if (cmd.mark || cmd.push)
            visit_mem[np_reg] <= 1'b1;
        visit_rd_reg <= visit_mem[np_reg];
    end

    // Stack store: entries below the top; the top lives in registers
    always_ff @(posedge clk)
    begin
        if (cmd.push && !popped_reg)
            stack_mem[sp_m1[A_W-1:0]] <= {top_r_reg, top_c_reg, top_dir_reg};
        stack_rd_reg <= stack_mem[sp_m1[A_W-1:0]];
    end

    always_comb
    begin
        stat.start_eq_goal = (cfg.start_row == cfg.end_row) && (cfg.start_col == cfg.end_col);
        stat.start_outside = ({1'b0, cfg.start_row} >= cfg.rows_eff) ||
                             ({1'b0, cfg.start_col} >= cfg.cols_eff);
        stat.in_grid       = in_grid;
        stat.dir_last      = (top_dir_reg == DIR_W);
        stat.popped        = popped_reg;
        stat.cell_free     = grid_rd_reg && !visit_rd_reg;
        stat.at_goal       = (8'(nb_r_reg) == 8'(cfg.end_row)) &&
                             (8'(nb_c_reg) == 8'(cfg.end_col));
        stat.sp_zero       = (sp_reg == '0);
        stat.clear_last    = (clr_addr_reg == A_W'(USED - 1));
    end

    a_top_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.expand |-> ((8'(top_r_reg) < {1'b0, cfg.rows_eff}) &&
                        (8'(top_c_reg) < {1'b0, cfg.cols_eff})))
        else $error("top of stack lies outside the grid");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (sp_reg < SP_W'(USED)))
        else $error("push with a full stack");

endmodule
